FILE: src/linex_weighted_mean_loss_unit_assert.svh
// Assertion macros for the weighted mean LINEX loss unit.
// Used by the port checker only; no dependencies.
`ifndef LINEX_WEIGHTED_MEAN_LOSS_UNIT_ASSERT_SVH
`define LINEX_WEIGHTED_MEAN_LOSS_UNIT_ASSERT_SVH

// Checked outside reset.
`define LWML_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("lwml check failed");

// Checked at every edge, reset included.
`define LWML_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("lwml check failed");

`endif

FILE: src/lwml_pkg.sv
// Shared types, constants and tables of the weighted mean LINEX loss unit.
// No dependencies.
`timescale 1ns / 1ps
package lwml_pkg;

    localparam int FRAC_BITS       = 16;
    localparam int COUNT_BITS_DEF  = 20;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int X_W             = 34;
    localparam int OUT_W           = 48;
    localparam int EXP_TERMS       = 12;
    localparam int EXP_LIM         = 64 << FRAC_BITS;
    localparam logic [15:0] ASYM_RESET = 16'd6554;
    localparam logic [30:0] LOG2E_Q30  = 31'd1549082005;
    localparam logic [31:0] LN2_Q32    = 32'd2977044472;
    localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

    typedef struct packed {
        logic signed [31:0] target;
        logic signed [31:0] prediction;
        logic signed [31:0] offset;
        logic        [31:0] weight;
        logic               last_item;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] mean_loss;
        logic             overflow;
        logic             empty_weight;
    } t_out_item;

    // Scaled residual and weight, as handed from front to back.
    typedef struct packed {
        logic signed [X_W-1:0] x;
        logic [31:0]           weight;
        logic                  last_item;
    } t_qent;

    typedef struct packed {
        logic  valid;
        t_qent ent;
    } t_qpush;

    typedef struct packed {
        logic  nempty;
        t_qent head;
    } t_qhead;

    // floor(2^32 / k); k = 1 gives 2^32 so that the product is exact.
    function automatic logic [32:0] recip_k(input logic [3:0] k);
        logic [32:0] v;
        case (k)
            4'd1:    v = 33'h1_0000_0000;
            4'd2:    v = 33'd2147483648;
            4'd3:    v = 33'd1431655765;
            4'd4:    v = 33'd1073741824;
            4'd5:    v = 33'd858993459;
            4'd6:    v = 33'd715827882;
            4'd7:    v = 33'd613566756;
            4'd8:    v = 33'd536870912;
            4'd9:    v = 33'd477218588;
            4'd10:   v = 33'd429496729;
            4'd11:   v = 33'd390451572;
            4'd12:   v = 33'd357913941;
            default: v = 33'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: src/lwml_front.sv
// Front end: accepts observations, forms the scaled residual x = floor(a*r/2^16).
// Depends on lwml_pkg.
`timescale 1ns / 1ps
module lwml_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_acc,
    input  lwml_pkg::t_in_item i_item,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    output logic              o_busy,
    output lwml_pkg::t_qpush  o_push
);
    logic [15:0]                     r_asym;
    logic                            r_v;
    logic signed [33:0]              r_r;
    logic [31:0]                     r_w;
    logic                            r_last;
    logic signed [50:0]              n_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_asym <= lwml_pkg::ASYM_RESET;
            r_v    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_asym <= i_cfg_data;
            end
            r_v <= i_acc;
        end
        if (i_acc) begin
            r_r    <= 34'(i_item.target) - (34'(i_item.prediction) + 34'(i_item.offset));
            r_w    <= i_item.weight;
            r_last <= i_item.last_item;
        end
    end

    // 34x17 signed product; arithmetic shift gives the floor
    assign n_prod = 51'(r_r) * 51'($signed({1'b0, r_asym}));

    assign o_busy               = r_v;
    assign o_push.valid         = r_v;
    assign o_push.ent.x         = n_prod[49:16];
    assign o_push.ent.weight    = r_w;
    assign o_push.ent.last_item = r_last;
endmodule

FILE: src/lwml_queue.sv
// Short register queue between front and back end.
// Depends on lwml_pkg.
`timescale 1ns / 1ps
module lwml_queue #(
    parameter int DEPTH = lwml_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  lwml_pkg::t_qpush          i_push,
    input  logic                      i_pop,
    output lwml_pkg::t_qhead          o_head,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lwml_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;
    logic            n_pop;

    assign n_pop = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.valid) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (n_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push.valid) - CW'(n_pop);
        end
        if (i_push.valid) begin
            r_mem[r_wp] <= i_push.ent;
        end
    end

    assign o_head.nempty = (r_cnt != '0);
    assign o_head.head   = r_mem[r_rp];
    assign o_count       = r_cnt;
endmodule

FILE: src/lwml_back.sv
// Back end: exp series, loss term, weighted accumulation and final division.
// Depends on lwml_pkg.
`timescale 1ns / 1ps
module lwml_back #(
    parameter int COUNT_BITS = lwml_pkg::COUNT_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lwml_pkg::t_qhead    i_head,
    output logic                o_qpop,
    input  logic                i_pop,
    output logic                o_valid,
    output lwml_pkg::t_out_item o_out
);
    localparam int WS_W = 32 + COUNT_BITS;
    localparam int FB   = lwml_pkg::FRAC_BITS;
    localparam logic signed [33:0] LIM = 34'(lwml_pkg::EXP_LIM);

    typedef enum logic [3:0] {
        S_IDLE, S_LOG, S_FRAC, S_TMUL, S_TREC, S_TCOR, S_SCALE,
        S_LOSS, S_PLO, S_PHI, S_ACC, S_DIVST, S_DIV, S_DONE
    } t_state;

    t_state              r_state;
    logic signed [33:0]  r_x;
    logic [31:0]         r_w;
    logic                r_last, r_esat;
    logic signed [54:0]  r_y;
    logic [31:0]         r_u, r_p, r_q;
    logic [32:0]         r_term;
    logic [33:0]         r_sum;
    logic [3:0]          r_k;
    logic [47:0]         r_e, r_lt;
    logic [55:0]         r_plo, r_phi;
    logic [63:0]         r_loss, r_quo;
    logic [WS_W-1:0]     r_wsum, r_rem;
    logic                r_sat;
    logic [6:0]          r_cnt;
    logic                r_ovalid;
    lwml_pkg::t_out_item r_out;

    logic signed [54:0]  n_y;
    logic [63:0]         n_umul;
    logic [64:0]         n_pmul, n_qmul;
    logic [35:0]         n_qk, n_rem;
    logic [31:0]         n_qfix;
    logic signed [9:0]   n_s, n_neg;
    logic [49:0]         n_ewide;
    logic [47:0]         n_e;
    logic                n_esat;
    logic signed [50:0]  n_l;
    logic [79:0]         n_prod;
    logic [63:0]         n_p64;
    logic [64:0]         n_ladd;
    logic [WS_W:0]       n_wadd, n_rsh;

    always_comb begin
        // x lies in [-2^22, 2^22] here, so 24 signed bits hold it
        n_y    = 55'($signed(r_x[23:0])) * 55'($signed({1'b0, lwml_pkg::LOG2E_Q30}));
        n_umul = 64'(r_y[45:14]) * 64'(lwml_pkg::LN2_Q32);
        n_pmul = 65'(r_term) * 65'(r_u);
        n_qmul = 65'(r_p) * 65'(lwml_pkg::recip_k(r_k));
        n_qk   = 36'(r_q) * 36'(r_k);
        n_rem  = 36'(r_p) - n_qk;
        n_qfix = (n_rem >= 36'(r_k)) ? r_q + 32'd1 : r_q;
        // shift s = n + F - 32, n = floor(y / 2^46)
        n_s    = 10'($signed(r_y[54:46])) + 10'sd16 - 10'(32 - FB) - 10'sd16;
        n_neg  = -n_s;
        n_ewide = 50'(r_sum) << n_s[3:0];
        n_esat = 1'b0;
        n_e    = '0;
        if (!n_s[9]) begin
            if (n_s > 10'sd15 || n_ewide[49:48] != 2'b00) begin
                n_esat = 1'b1;
                n_e    = lwml_pkg::OUT_MAX;
            end else begin
                n_e = n_ewide[47:0];
            end
        end else if (n_neg < 10'sd34) begin
            n_e = 48'(r_sum >> n_neg[5:0]);
        end
        n_l    = $signed({3'b000, r_e}) - 51'(r_x) - (51'sd1 <<< FB);
        n_prod = {r_phi, 24'd0} + 80'(r_plo);
        n_p64  = (n_prod[79:64] != '0) ? {64{1'b1}} : n_prod[63:0];
        n_ladd = {1'b0, r_loss} + {1'b0, n_p64};
        n_wadd = {1'b0, r_wsum} + (WS_W + 1)'(r_w);
        n_rsh  = {r_rem, r_quo[63]};
    end

    assign o_qpop  = (r_state == S_IDLE) && i_head.nempty;
    assign o_valid = r_ovalid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_loss   <= '0;
            r_wsum   <= '0;
            r_sat    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_pop && r_ovalid) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.nempty) begin
                        r_x     <= i_head.head.x;
                        r_w     <= i_head.head.weight;
                        r_last  <= i_head.head.last_item;
                        r_state <= S_LOG;
                    end
                end
                S_LOG: begin
                    r_esat <= 1'b0;
                    if (r_x > LIM) begin
                        r_esat  <= 1'b1;
                        r_e     <= lwml_pkg::OUT_MAX;
                        r_state <= S_LOSS;
                    end else if (r_x < -LIM) begin
                        r_e     <= '0;
                        r_state <= S_LOSS;
                    end else begin
                        r_y     <= n_y;
                        r_state <= S_FRAC;
                    end
                end
                S_FRAC: begin
                    r_u     <= n_umul[63:32];
                    r_term  <= 33'h1_0000_0000;
                    r_sum   <= 34'h1_0000_0000;
                    r_k     <= 4'd1;
                    r_state <= S_TMUL;
                end
                S_TMUL: begin
                    r_p     <= n_pmul[63:32];
                    r_state <= S_TREC;
                end
                S_TREC: begin
                    r_q     <= n_qmul[63:32];
                    r_state <= S_TCOR;
                end
                S_TCOR: begin
                    r_term <= 33'(n_qfix);
                    r_sum  <= r_sum + 34'(n_qfix);
                    if (r_k == 4'(lwml_pkg::EXP_TERMS)) begin
                        r_state <= S_SCALE;
                    end else begin
                        r_k     <= r_k + 4'd1;
                        r_state <= S_TMUL;
                    end
                end
                S_SCALE: begin
                    r_e     <= n_e;
                    r_esat  <= n_esat;
                    r_state <= S_LOSS;
                end
                S_LOSS: begin
                    if (r_esat) begin
                        r_lt  <= lwml_pkg::OUT_MAX;
                        r_sat <= 1'b1;
                    end else if (n_l < 0) begin
                        r_lt <= '0;
                    end else if (n_l[50:48] != 3'b000) begin
                        r_lt  <= lwml_pkg::OUT_MAX;
                        r_sat <= 1'b1;
                    end else begin
                        r_lt <= n_l[47:0];
                    end
                    r_state <= S_PLO;
                end
                S_PLO: begin
                    r_plo   <= 56'(r_lt[23:0]) * 56'(r_w);
                    r_state <= S_PHI;
                end
                S_PHI: begin
                    r_phi   <= 56'(r_lt[47:24]) * 56'(r_w);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (n_prod[79:64] != '0 || n_ladd[64]) begin
                        r_sat <= 1'b1;
                    end
                    r_loss <= n_ladd[64] ? {64{1'b1}} : n_ladd[63:0];
                    if (n_wadd[WS_W]) begin
                        r_wsum <= {WS_W{1'b1}};
                        r_sat  <= 1'b1;
                    end else begin
                        r_wsum <= n_wadd[WS_W-1:0];
                    end
                    r_state <= r_last ? S_DIVST : S_IDLE;
                end
                S_DIVST: begin
                    r_rem   <= '0;
                    r_quo   <= r_loss;
                    r_cnt   <= 7'd64;
                    r_state <= (r_wsum == '0) ? S_DONE : S_DIV;
                end
                S_DIV: begin
                    // one quotient bit per cycle
                    if (n_rsh >= {1'b0, r_wsum}) begin
                        r_rem <= WS_W'(n_rsh - {1'b0, r_wsum});
                        r_quo <= {r_quo[62:0], 1'b1};
                    end else begin
                        r_rem <= n_rsh[WS_W-1:0];
                        r_quo <= {r_quo[62:0], 1'b0};
                    end
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == 7'd1) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        if (r_wsum == '0) begin
                            r_out.mean_loss    <= '0;
                            r_out.overflow     <= r_sat;
                            r_out.empty_weight <= 1'b1;
                        end else begin
                            r_out.empty_weight <= 1'b0;
                            if (r_quo[63:48] != '0) begin
                                r_out.mean_loss <= lwml_pkg::OUT_MAX;
                                r_out.overflow  <= 1'b1;
                            end else begin
                                r_out.mean_loss <= r_quo[47:0];
                                r_out.overflow  <= r_sat;
                            end
                        end
                        r_loss  <= '0;
                        r_wsum  <= '0;
                        r_sat   <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: src/linex_weighted_mean_loss_unit.sv
// Top level of the weighted mean LINEX loss unit: front end, queue, back end.
// Depends on lwml_pkg, lwml_front, lwml_queue, lwml_back.
//
// Usage
//   Input queue side: drive i_in and raise push; the request is taken at an edge
//   where push is high and full is low. last_item closes a set.
//   Result queue side: while empty is low, o_out holds the mean loss of the last
//   closed set; raise pop to take it. Only a closing request makes a result.
//   Config: i_cfg_data (asymmetry a, Q0.16) is written when i_cfg_valid and
//   o_cfg_ready are high; o_cfg_ready is always high. Write only while idle.
// Timing
//   The front end takes a request per cycle while full is low into a short
//   queue. The back end takes one request at a time: a 12-term exp series
//   (multiply, reciprocal multiply, correct per term), skipped when the exp
//   argument is out of range. A closing request adds a 64-step bit-serial division.
// Reset clears the sums, flags, queue and result slot; a returns to 0.1.
// If the receiver stalls, the back end waits with the finished result and the
// queue keeps taking requests until it fills, then full rises.
`timescale 1ns / 1ps
module linex_weighted_mean_loss_unit #(
    parameter int COUNT_BITS  = lwml_pkg::COUNT_BITS_DEF,
    parameter int QUEUE_DEPTH = lwml_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  lwml_pkg::t_in_item  i_in,
    output logic                empty,
    input  logic                pop,
    output lwml_pkg::t_out_item o_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data
);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    lwml_pkg::t_qpush w_push;
    lwml_pkg::t_qhead w_head;
    logic [CW-1:0]    w_count;
    logic             w_busy, w_qpop, w_ovalid, w_acc;

    assign o_cfg_ready = 1'b1;
    // room for the queue contents plus the one request in the front stage
    assign full  = (CW'(w_count) + CW'(w_busy)) >= CW'(QUEUE_DEPTH);
    assign w_acc = push && !full;
    assign empty = !w_ovalid;

    lwml_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (w_acc),
        .i_item     (i_in),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_busy     (w_busy),
        .o_push     (w_push)
    );

    lwml_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_qpop),
        .o_head  (w_head),
        .o_count (w_count)
    );

    lwml_back #(.COUNT_BITS(COUNT_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .o_qpop  (w_qpop),
        .i_pop   (pop),
        .o_valid (w_ovalid),
        .o_out   (o_out)
    );
endmodule

FILE: src/lwml_checker.sv
// Port-level checks of the weighted mean LINEX loss unit, bound to the top level.
// Depends on lwml_pkg and linex_weighted_mean_loss_unit_assert.svh.
`timescale 1ns / 1ps
`include "linex_weighted_mean_loss_unit_assert.svh"
module lwml_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                full,
    input logic                empty,
    input logic                pop,
    input lwml_pkg::t_out_item o_out
);
    `LWML_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> empty)
    `LWML_ASSERT_ALWAYS(a_rst_room, i_clk, !i_rst_n |=> !full)
    `LWML_ASSERT(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_out)))
    `LWML_ASSERT(a_empty_zero, i_clk, i_rst_n, (!empty && o_out.empty_weight) |-> (o_out.mean_loss == '0))
endmodule

bind linex_weighted_mean_loss_unit lwml_checker u_lwml_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

FILE: tb/linex_weighted_mean_loss_unit_tb.sv
// Self-checking testbench for linex_weighted_mean_loss_unit: random and directed
// observation sets, with a bit-exact fixed-point loss predictor in a scoreboard.
// Depends on lwml_pkg and the unit's RTL.
`timescale 1ns / 1ps
module linex_weighted_mean_loss_unit_tb;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int     SETTLE      = 250;   // worst request latency plus margin
    localparam int     ITEM_TARGET = 1700;
    localparam logic [63:0] WSUM_MAX = (64'd1 << (32 + lwml_pkg::COUNT_BITS_DEF)) - 1;
    localparam logic [63:0] OUT_MAX64 = {16'd0, lwml_pkg::OUT_MAX};

    // Predicts the mean loss of each closed set and holds it until popped.
    class loss_scoreboard;
        logic [15:0]         asym;
        logic [63:0]         loss_acc;
        logic [63:0]         weight_acc;
        bit                  sat_flag;
        lwml_pkg::t_out_item due[$];
        int                  errors;

        function new();
            asym       = lwml_pkg::ASYM_RESET;
            loss_acc   = 0;
            weight_acc = 0;
            sat_flag   = 0;
            errors     = 0;
        endfunction

        function int waiting();
            return due.size();
        endfunction

        // Fixed-point exp of a Q.16 argument; range reduction then 12-term series.
        function logic [63:0] fx_exp(input longint x, output bit esat);
            longint      y;
            longint      n;
            longint      s;
            logic [63:0] frac;
            logic [63:0] u;
            logic [63:0] term;
            logic [63:0] acc;
            logic [63:0] e;
            esat = 0;
            if (x > longint'(lwml_pkg::EXP_LIM)) begin
                esat = 1;
                return OUT_MAX64;
            end
            if (x < -longint'(lwml_pkg::EXP_LIM))
                return 0;
            y    = x * longint'({33'd0, lwml_pkg::LOG2E_Q30});
            n    = y >>> (lwml_pkg::FRAC_BITS + 30);
            frac = (64'(y) & ((64'd1 << (lwml_pkg::FRAC_BITS + 30)) - 1))
                   >> (lwml_pkg::FRAC_BITS - 2);
            u    = (frac * {32'd0, lwml_pkg::LN2_Q32}) >> 32;
            term = 64'd1 << 32;
            acc  = term;
            for (int k = 1; k <= lwml_pkg::EXP_TERMS; k++) begin
                term = ((term * u) >> 32) / k;
                acc  = acc + term;
            end
            s = n + lwml_pkg::FRAC_BITS - 32;
            if (s >= 0) begin
                if (s > 15) begin
                    esat = 1;
                    return OUT_MAX64;
                end
                e = acc << s;
                if (e > OUT_MAX64) begin
                    esat = 1;
                    return OUT_MAX64;
                end
                return e;
            end
            if (-s >= 64)
                return 0;
            return acc >> (-s);
        endfunction

        function void note_request(input lwml_pkg::t_in_item it);
            longint              r;
            longint              x;
            longint              l;
            bit                  esat;
            logic [63:0]         e;
            logic [63:0]         lt;
            logic [63:0]         w;
            logic [127:0]        p;
            logic [64:0]         sum;
            lwml_pkg::t_out_item res;
            r = longint'(it.target) - (longint'(it.prediction) + longint'(it.offset));
            x = (longint'({48'd0, asym}) * r) >>> 16;
            e = fx_exp(x, esat);
            if (esat) begin
                lt       = OUT_MAX64;
                sat_flag = 1;
            end else begin
                l = longint'(e) - x - (longint'(1) << lwml_pkg::FRAC_BITS);
                if (l < 0)
                    l = 0;
                if (64'(l) > OUT_MAX64) begin
                    lt       = OUT_MAX64;
                    sat_flag = 1;
                end else begin
                    lt = 64'(l);
                end
            end
            w = {32'd0, it.weight};
            p = {64'd0, lt} * {64'd0, w};
            if (p[127:64] != 0) begin
                p        = {64'd0, {64{1'b1}}};
                sat_flag = 1;
            end
            sum = {1'b0, loss_acc} + {1'b0, p[63:0]};
            if (sum[64]) begin
                loss_acc = {64{1'b1}};
                sat_flag = 1;
            end else begin
                loss_acc = sum[63:0];
            end
            if (w > WSUM_MAX - weight_acc) begin
                weight_acc = WSUM_MAX;
                sat_flag   = 1;
            end else begin
                weight_acc = weight_acc + w;
            end
            if (!it.last_item)
                return;
            if (weight_acc == 0) begin
                res.mean_loss    = 0;
                res.overflow     = sat_flag;
                res.empty_weight = 1;
            end else begin
                sum = {1'b0, loss_acc / weight_acc};
                res.overflow     = sat_flag;
                res.empty_weight = 0;
                if (sum[63:0] > OUT_MAX64) begin
                    res.mean_loss = lwml_pkg::OUT_MAX;
                    res.overflow  = 1;
                end else begin
                    res.mean_loss = sum[lwml_pkg::OUT_W-1:0];
                end
            end
            due.push_back(res);
            loss_acc   = 0;
            weight_acc = 0;
            sat_flag   = 0;
        endfunction

        function void check_result(input lwml_pkg::t_out_item got);
            lwml_pkg::t_out_item want;
            if (due.size() == 0) begin
                $error("unexpected result: mean_loss %0d", got.mean_loss);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.mean_loss !== want.mean_loss) begin
                $error("mean_loss: expected %0d, got %0d", want.mean_loss, got.mean_loss);
                errors++;
            end
            if (got.overflow !== want.overflow) begin
                $error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
                errors++;
            end
            if (got.empty_weight !== want.empty_weight) begin
                $error("empty_weight: expected %0d, got %0d",
                       want.empty_weight, got.empty_weight);
                errors++;
            end
        endfunction
    endclass

    logic                i_clk = 0;
    logic                i_rst_n = 0;
    logic                push = 0;
    logic                full;
    lwml_pkg::t_in_item  i_in = '0;
    logic                empty;
    logic                pop = 0;
    lwml_pkg::t_out_item o_out;
    logic                i_cfg_valid = 0;
    logic                o_cfg_ready;
    logic [15:0]         i_cfg_data = 16'd0;

    loss_scoreboard sb = new();
    longint cycles = 0;
    int     sent = 0;
    bit     tx_burst = 0;   // phases with no sender gaps
    bit     rx_burst = 0;   // phases with no receiver stalls

    linex_weighted_mean_loss_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1;
        #1 i_clk = 0;
    end

    // Watch both handshakes on pre-edge values.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && push && !full)
            sb.note_request(i_in);
        if (i_rst_n && pop && !empty)
            sb.check_result(o_out);
        if (cycles > CYCLE_LIMIT) begin
            $display("linex_weighted_mean_loss_unit regression: fail");
            $finish;
        end
    end

    // Receiver: random stall before each pop, none in burst phases.
    initial begin
        int gap;
        @(posedge i_clk);
        wait (i_rst_n);
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                pop <= 0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1;
            do @(posedge i_clk); while (empty);
        end
    end

    // One request; push stays high across back-to-back requests.
    task automatic send_request(input lwml_pkg::t_in_item it);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1;
        i_in <= it;
        do @(posedge i_clk); while (full);
        sent++;
    endtask

    // One edge first so that the last accepted request is already noted.
    task automatic drain();
        push <= 0;
        @(posedge i_clk);
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_asym(input logic [15:0] a);
        i_cfg_valid <= 1;
        i_cfg_data  <= a;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        sb.asym = a;
    endtask

    function automatic logic [31:0] signed_span(input int bits);
        logic [31:0] v;
        v = $urandom & ((32'd1 << bits) - 1);
        return $urandom_range(0, 1) ? -v : v;
    endfunction

    // Mostly residuals near the exp range, some full-width noise.
    function automatic lwml_pkg::t_in_item random_obs(input bit last);
        lwml_pkg::t_in_item it;
        int                 mode;
        mode = $urandom_range(0, 9);
        if (mode == 0) begin
            it = {$urandom, $urandom, $urandom, $urandom, 1'b0};
        end else begin
            it.target     = signed_span($urandom_range(4, 27));
            it.prediction = signed_span($urandom_range(4, 27));
            it.offset     = $urandom_range(0, 1) ? 32'd0 : signed_span($urandom_range(1, 20));
            case ($urandom_range(0, 7))
                0:       it.weight = 0;
                1:       it.weight = $urandom;
                default: it.weight = $urandom_range(0, 1 << 18);
            endcase
        end
        it.last_item = last;
        return it;
    endfunction

    function automatic lwml_pkg::t_in_item obs(input logic [31:0] t, input logic [31:0] p,
                                               input logic [31:0] o, input logic [31:0] w,
                                               input bit last);
        lwml_pkg::t_in_item it;
        it.target     = t;
        it.prediction = p;
        it.offset     = o;
        it.weight     = w;
        it.last_item  = last;
        return it;
    endfunction

    task automatic random_sets(input int n_items);
        int stop;
        int len;
        bit zero_set;
        stop = sent + n_items;
        while (sent < stop) begin
            len      = $urandom_range(1, 6);
            zero_set = ($urandom_range(0, 19) == 0);
            for (int i = 0; i < len; i++) begin
                lwml_pkg::t_in_item it;
                it = random_obs(i == len - 1);
                if (zero_set)
                    it.weight = 0;
                send_request(it);
            end
        end
    endtask

    initial begin
        logic [15:0] asym_list[8];
        int per_phase;
        asym_list = '{16'd6554, 16'd1, 16'd65535, 16'd0, 16'd32768,
                      16'($urandom), 16'($urandom_range(1, 4096)), 16'd6554};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed sets at the reset asymmetry.
        send_request(obs(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h0001_0000, 1));
        send_request(obs(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1));
        send_request(obs(32'h0, 32'h0, 32'h0, 32'h0001_0000, 1));          // zero residual
        send_request(obs(32'h0010_0000, 32'h0, 32'h0, 32'h0, 0));          // empty set
        send_request(obs(32'h0, 32'h0020_0000, 32'h0, 32'h0, 1));
        send_request(obs(32'h7fff_ffff, 32'h0, 32'h0, 32'h0, 1));          // exp sat, weight 0
        send_request(obs(32'h0300_0000, 32'h0, 32'hffff_0000, 32'hffff_ffff, 0));
        send_request(obs(32'h0300_0000, 32'h0, 32'h0, 32'hffff_ffff, 1));  // product / sum sat
        send_request(obs(32'h0028_0000, 32'h0, 32'h0, 32'h0000_0001, 0));  // x near +4
        send_request(obs(32'h0, 32'h0028_0000, 32'h0, 32'h0000_8000, 0));  // x near -4
        send_request(obs(32'h0001_0000, 32'h0000_8000, 32'h0, 32'h0002_0000, 1));
        send_request(obs(32'h8000_0000, 32'h0, 32'h0, 32'h0000_0001, 1));  // exp underflow
        send_request(obs(32'hffff_ffff, 32'h0000_0001, 32'h7fff_ffff, 32'h8000_0000, 1));

        drain();   // sender holds off until every result is in
        per_phase = ITEM_TARGET / 8;
        foreach (asym_list[i]) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            write_asym(asym_list[i]);
            random_sets(per_phase);
            drain();
        end

        if (sb.errors == 0 && sb.waiting() == 0)
            $display("linex_weighted_mean_loss_unit regression: pass");
        else
            $display("linex_weighted_mean_loss_unit regression: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+src
src/lwml_pkg.sv
src/lwml_front.sv
src/lwml_queue.sv
src/lwml_back.sv
src/linex_weighted_mean_loss_unit.sv
src/lwml_checker.sv
tb/linex_weighted_mean_loss_unit_tb.sv
